// ----- hw/rtl/xenc_pkg.sv -----
// ----------------------------------------------------------------------------
// xenc_pkg
// Shared types, opcode constants and table functions for the x86-64 encoder.
// ----------------------------------------------------------------------------
package xenc_pkg;

   localparam int MAX_BYTES = 10;

   typedef enum logic [4:0] {
      OP_NOP       = 5'd0,
      OP_RET       = 5'd1,
      OP_INC       = 5'd2,
      OP_DEC       = 5'd3,
      OP_NEG       = 5'd4,
      OP_CALL      = 5'd5,
      OP_PUSH      = 5'd6,
      OP_POP       = 5'd7,
      OP_IDIV      = 5'd8,
      OP_JMP       = 5'd9,
      OP_JNE       = 5'd10,
      OP_MOVZX     = 5'd11,
      OP_SETL      = 5'd12,
      OP_SETG      = 5'd13,
      OP_SETE      = 5'd14,
      OP_ADD_RR    = 5'd15,
      OP_ADD_RI    = 5'd16,
      OP_SUB_RR    = 5'd17,
      OP_SUB_RI    = 5'd18,
      OP_CMP_RR    = 5'd19,
      OP_CMP_RI    = 5'd20,
      OP_OR_RR     = 5'd21,
      OP_OR_RI     = 5'd22,
      OP_AND_RR    = 5'd23,
      OP_AND_RI    = 5'd24,
      OP_IMUL_RR   = 5'd25,
      OP_IMUL_RI   = 5'd26,
      OP_MOV_RR    = 5'd27,
      OP_MOV_RI    = 5'd28,
      OP_MOV_LOAD  = 5'd29,
      OP_MOV_STORE = 5'd30,
      OP_UNUSED    = 5'd31
   } op_type;

   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_SUB = 3'd1;
   localparam logic [2:0] ALU_CMP = 3'd2;
   localparam logic [2:0] ALU_OR  = 3'd3;

   localparam logic [7:0] REX_W    = 8'h48;
   localparam logic [7:0] REX_R    = 8'h04;
   localparam logic [7:0] REX_B    = 8'h01;
   localparam logic [7:0] MOD_REG  = 8'hC0;
   localparam logic [7:0] MOD_D8   = 8'h40;
   localparam logic [7:0] MOD_D32  = 8'h80;
   localparam logic [7:0] ESC_0F   = 8'h0F;
   localparam logic [7:0] ALU_I32  = 8'h81;
   localparam logic [7:0] ALU_I8   = 8'h83;
   localparam logic [7:0] MOV_STR  = 8'h89;
   localparam logic [7:0] MOV_LD   = 8'h8B;
   localparam logic [7:0] SIB_RSP  = 8'h24;
   localparam logic [7:0] REX_B_ONLY = 8'h41;

   typedef struct packed {
      logic [4:0]         operation;
      logic [3:0]         dest_reg;
      logic [3:0]         src_reg;
      logic signed [63:0] immediate;
      logic signed [31:0] displacement;
   } req_type;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic        last_byte;
      logic [15:0] start_offset;
   } rsp_type;

   // encoded instruction, byte 0 first
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] code;
      logic [3:0]                len;
   } enc_type;

   function automatic logic [7:0] rex_of(logic [3:0] reg_f, logic [3:0] rm_f);
      rex_of = REX_W | (reg_f[3] ? REX_R : 8'h00) | (rm_f[3] ? REX_B : 8'h00);
   endfunction

   function automatic logic fits8_64(logic [63:0] v);
      fits8_64 = (&v[63:7]) || !(|v[63:7]);
   endfunction

   function automatic logic fits32_64(logic [63:0] v);
      fits32_64 = (&v[63:31]) || !(|v[63:31]);
   endfunction

   function automatic logic fits8_32(logic [31:0] v);
      fits8_32 = (&v[31:7]) || !(|v[31:7]);
   endfunction

   function automatic logic [7:0] alu_rr_op(logic [2:0] k);
      case (k)
         ALU_ADD: alu_rr_op = 8'h01;
         ALU_SUB: alu_rr_op = 8'h29;
         ALU_CMP: alu_rr_op = 8'h39;
         ALU_OR:  alu_rr_op = 8'h09;
         default: alu_rr_op = 8'h21;
      endcase
   endfunction

   function automatic logic [2:0] alu_ext(logic [2:0] k);
      case (k)
         ALU_ADD: alu_ext = 3'd0;
         ALU_SUB: alu_ext = 3'd5;
         ALU_CMP: alu_ext = 3'd7;
         ALU_OR:  alu_ext = 3'd1;
         default: alu_ext = 3'd4;
      endcase
   endfunction

   function automatic logic [7:0] alu_acc_op(logic [2:0] k);
      case (k)
         ALU_ADD: alu_acc_op = 8'h05;
         ALU_SUB: alu_acc_op = 8'h2D;
         ALU_CMP: alu_acc_op = 8'h3D;
         ALU_OR:  alu_acc_op = 8'h0D;
         default: alu_acc_op = 8'h25;
      endcase
   endfunction

endpackage

// ----- hw/rtl/x86_64_instruction_encoder.sv -----
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder
// Encodes instruction requests into x86-64 machine code, one byte per item.
// ----------------------------------------------------------------------------
//   channel  direction  payload            handshake
//   req      in         xenc_pkg::req_type req_valid / req_ready
//   rsp      out        xenc_pkg::rsp_type rsp_valid / rsp_ready
//
// An instruction of 1 to 10 code bytes leaves one byte per cycle while rsp_ready
// is high; the byte serializer sets the rate. The next request
// waits in the input register and is encoded while the previous one drains.
// Reset clears the valid flags and the code offset to zero.
// A stalled rsp holds the current byte; the input register then fills and
// req_ready drops until the serializer takes the held request.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder #(
   parameter int OFFSET_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xenc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xenc_pkg::rsp_type rsp_data
);

   logic              hold_valid_ff, hold_valid_in;
   xenc_pkg::req_type hold_ff, hold_in;
   xenc_pkg::enc_type enc_item;
   logic              enc_ready;

   assign req_ready = !hold_valid_ff || enc_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
         hold_in       = req_data;
      end else if (enc_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   xenc_encode u_encode (
      .req (hold_ff),
      .enc (enc_item)
   );

   xenc_emit #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .enc_valid (hold_valid_ff),
      .enc_ready (enc_ready),
      .enc       (enc_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_hold_kept: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !enc_ready |=> hold_valid_ff && $stable(hold_ff))
      else $error("held request lost while serializer busy");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> hold_valid_ff)
      else $error("accepted request not held");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> enc_item.len <= 4'(xenc_pkg::MAX_BYTES))
      else $error("encoded length out of range");

   a_unused_empty: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && hold_ff.operation == 5'(xenc_pkg::OP_UNUSED)
      |-> enc_item.len == 4'd0)
      else $error("unused operation produced code");

endmodule

// ----- hw/rtl/xenc_encode.sv -----
// ----------------------------------------------------------------------------
// xenc_encode
// Combinational encoder: one request into up to ten code bytes and a length.
// ----------------------------------------------------------------------------
module xenc_encode (
   input  xenc_pkg::req_type req,
   output xenc_pkg::enc_type enc
);

   always_comb begin
      logic [3:0]  d;
      logic [3:0]  s;
      logic [3:0]  reg_f;
      logic [3:0]  rm_f;
      logic [4:0]  alu_off;
      logic [2:0]  k;
      logic [63:0] imm;
      logic [31:0] disp;
      logic        sib;
      logic        short_disp;
      logic [3:0]  p;

      d       = req.dest_reg;
      s       = req.src_reg;
      imm     = req.immediate;
      disp    = req.displacement;
      alu_off = req.operation - 5'(xenc_pkg::OP_ADD_RR);
      k       = alu_off[3:1];
      reg_f   = '0;
      rm_f    = '0;
      sib     = 1'b0;
      short_disp = 1'b0;
      p       = '0;
      enc.code = '0;
      enc.len  = '0;

      unique case (xenc_pkg::op_type'(req.operation))
         xenc_pkg::OP_NOP: begin
            enc.code[0] = 8'h90;
            enc.len = 4'd1;
         end
         xenc_pkg::OP_RET: begin
            enc.code[0] = 8'hC3;
            enc.len = 4'd1;
         end
         xenc_pkg::OP_INC, xenc_pkg::OP_DEC, xenc_pkg::OP_NEG, xenc_pkg::OP_IDIV: begin
            enc.code[0] = xenc_pkg::rex_of(4'd0, d);
            case (xenc_pkg::op_type'(req.operation))
               xenc_pkg::OP_INC: begin
                  enc.code[1] = 8'hFF;
                  enc.code[2] = 8'hC0 | {5'd0, d[2:0]};
               end
               xenc_pkg::OP_DEC: begin
                  enc.code[1] = 8'hFF;
                  enc.code[2] = 8'hC8 | {5'd0, d[2:0]};
               end
               xenc_pkg::OP_NEG: begin
                  enc.code[1] = 8'hF7;
                  enc.code[2] = 8'hD8 | {5'd0, d[2:0]};
               end
               default: begin
                  enc.code[1] = 8'hF7;
                  enc.code[2] = 8'hF8 | {5'd0, d[2:0]};
               end
            endcase
            enc.len = 4'd3;
         end
         xenc_pkg::OP_CALL: begin
            if (d[3]) begin
               enc.code[0] = xenc_pkg::REX_B_ONLY;
               enc.code[1] = 8'hFF;
               enc.code[2] = 8'hD0 | {5'd0, d[2:0]};
               enc.len = 4'd3;
            end else begin
               enc.code[0] = 8'hFF;
               enc.code[1] = 8'hD0 | {5'd0, d[2:0]};
               enc.len = 4'd2;
            end
         end
         xenc_pkg::OP_PUSH, xenc_pkg::OP_POP: begin
            p = {3'd0, d[3]};
            enc.code[0] = xenc_pkg::REX_B_ONLY;
            enc.code[p] = ((req.operation == 5'(xenc_pkg::OP_PUSH)) ? 8'h50 : 8'h58)
                          | {5'd0, d[2:0]};
            enc.len = p + 4'd1;
         end
         xenc_pkg::OP_JMP: begin
            enc.code[0] = 8'hE9;
            for (int i = 0; i < 4; i++) begin
               enc.code[1+i] = disp[8*i +: 8];
            end
            enc.len = 4'd5;
         end
         xenc_pkg::OP_JNE: begin
            enc.code[0] = xenc_pkg::ESC_0F;
            enc.code[1] = 8'h85;
            for (int i = 0; i < 4; i++) begin
               enc.code[2+i] = disp[8*i +: 8];
            end
            enc.len = 4'd6;
         end
         xenc_pkg::OP_MOVZX: begin
            enc.code[0] = xenc_pkg::rex_of(d, 4'd0);
            enc.code[1] = xenc_pkg::ESC_0F;
            enc.code[2] = 8'hB6;
            enc.code[3] = xenc_pkg::MOD_REG | {2'd0, d[2:0], 3'd0};
            enc.len = 4'd4;
         end
         xenc_pkg::OP_SETL, xenc_pkg::OP_SETG, xenc_pkg::OP_SETE: begin
            enc.code[0] = xenc_pkg::ESC_0F;
            case (xenc_pkg::op_type'(req.operation))
               xenc_pkg::OP_SETL: enc.code[1] = 8'h9C;
               xenc_pkg::OP_SETG: enc.code[1] = 8'h9F;
               default:           enc.code[1] = 8'h94;
            endcase
            enc.code[2] = xenc_pkg::MOD_REG;
            enc.len = 4'd3;
         end
         xenc_pkg::OP_ADD_RR, xenc_pkg::OP_SUB_RR, xenc_pkg::OP_CMP_RR,
         xenc_pkg::OP_OR_RR, xenc_pkg::OP_AND_RR: begin
            reg_f = (k == xenc_pkg::ALU_CMP) ? d : s;
            rm_f  = (k == xenc_pkg::ALU_CMP) ? s : d;
            enc.code[0] = xenc_pkg::rex_of(reg_f, rm_f);
            enc.code[1] = xenc_pkg::alu_rr_op(k);
            enc.code[2] = xenc_pkg::MOD_REG | {2'd0, reg_f[2:0], rm_f[2:0]};
            enc.len = 4'd3;
         end
         xenc_pkg::OP_ADD_RI, xenc_pkg::OP_SUB_RI, xenc_pkg::OP_CMP_RI,
         xenc_pkg::OP_OR_RI, xenc_pkg::OP_AND_RI: begin
            enc.code[0] = xenc_pkg::rex_of(4'd0, d);
            if (xenc_pkg::fits8_64(imm)) begin
               enc.code[1] = xenc_pkg::ALU_I8;
               enc.code[2] = xenc_pkg::MOD_REG | {2'd0, xenc_pkg::alu_ext(k), d[2:0]};
               enc.code[3] = imm[7:0];
               enc.len = 4'd4;
            end else if (d == 4'd0) begin
               enc.code[1] = xenc_pkg::alu_acc_op(k);
               for (int i = 0; i < 4; i++) begin
                  enc.code[2+i] = imm[8*i +: 8];
               end
               enc.len = 4'd6;
            end else begin
               enc.code[1] = xenc_pkg::ALU_I32;
               enc.code[2] = xenc_pkg::MOD_REG | {2'd0, xenc_pkg::alu_ext(k), d[2:0]};
               for (int i = 0; i < 4; i++) begin
                  enc.code[3+i] = imm[8*i +: 8];
               end
               enc.len = 4'd7;
            end
         end
         xenc_pkg::OP_IMUL_RR: begin
            enc.code[0] = xenc_pkg::rex_of(d, s);
            enc.code[1] = xenc_pkg::ESC_0F;
            enc.code[2] = 8'hAF;
            enc.code[3] = xenc_pkg::MOD_REG | {2'd0, d[2:0], s[2:0]};
            enc.len = 4'd4;
         end
         xenc_pkg::OP_IMUL_RI: begin
            enc.code[0] = xenc_pkg::rex_of(d, d);
            enc.code[1] = 8'h69;
            enc.code[2] = xenc_pkg::MOD_REG | {2'd0, d[2:0], d[2:0]};
            for (int i = 0; i < 4; i++) begin
               enc.code[3+i] = imm[8*i +: 8];
            end
            enc.len = 4'd7;
         end
         xenc_pkg::OP_MOV_RR: begin
            enc.code[0] = xenc_pkg::rex_of(s, d);
            enc.code[1] = xenc_pkg::MOV_STR;
            enc.code[2] = xenc_pkg::MOD_REG | {2'd0, s[2:0], d[2:0]};
            enc.len = 4'd3;
         end
         xenc_pkg::OP_MOV_RI: begin
            enc.code[0] = xenc_pkg::rex_of(4'd0, d);
            if (xenc_pkg::fits32_64(imm)) begin
               enc.code[1] = 8'hC7;
               enc.code[2] = xenc_pkg::MOD_REG | {5'd0, d[2:0]};
               for (int i = 0; i < 4; i++) begin
                  enc.code[3+i] = imm[8*i +: 8];
               end
               enc.len = 4'd7;
            end else begin
               enc.code[1] = 8'hB8 | {5'd0, d[2:0]};
               for (int i = 0; i < 8; i++) begin
                  enc.code[2+i] = imm[8*i +: 8];
               end
               enc.len = 4'd10;
            end
         end
         xenc_pkg::OP_MOV_LOAD, xenc_pkg::OP_MOV_STORE: begin
            reg_f = (req.operation == 5'(xenc_pkg::OP_MOV_LOAD)) ? d : s;
            rm_f  = (req.operation == 5'(xenc_pkg::OP_MOV_LOAD)) ? s : d;
            sib        = (rm_f[2:0] == 3'd4);
            short_disp = xenc_pkg::fits8_32(disp);
            p          = sib ? 4'd4 : 4'd3;
            enc.code[0] = xenc_pkg::rex_of(reg_f, rm_f);
            enc.code[1] = (req.operation == 5'(xenc_pkg::OP_MOV_LOAD)) ?
                          xenc_pkg::MOV_LD : xenc_pkg::MOV_STR;
            enc.code[2] = (short_disp ? xenc_pkg::MOD_D8 : xenc_pkg::MOD_D32)
                          | {2'd0, reg_f[2:0], rm_f[2:0]};
            enc.code[3] = xenc_pkg::SIB_RSP;
            if (short_disp) begin
               enc.code[p] = disp[7:0];
               enc.len = p + 4'd1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  enc.code[p + 4'(i)] = disp[8*i +: 8];
               end
               enc.len = p + 4'd4;
            end
         end
         xenc_pkg::OP_UNUSED: begin
            enc.len = 4'd0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/xenc_emit.sv -----
// ----------------------------------------------------------------------------
// xenc_emit
// Byte serializer: holds one encoded instruction, sends a byte per cycle while
// rsp_ready is high and keeps the running code offset.
// ----------------------------------------------------------------------------
module xenc_emit #(
   parameter int OFFSET_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enc_valid,
   output logic              enc_ready,
   input  xenc_pkg::enc_type enc,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xenc_pkg::rsp_type rsp_data
);

   logic                                 busy_ff, busy_in;
   logic [3:0]                           left_ff, left_in;
   logic [xenc_pkg::MAX_BYTES-1:0][7:0]  code_ff, code_in;
   logic [OFFSET_BITS-1:0]               start_ff, start_in;
   logic [OFFSET_BITS-1:0]               offset_ff, offset_in;
   logic [OFFSET_BITS+15:0]              start_ext;
   logic                                 take;
   logic                                 load;

   assign take      = busy_ff && rsp_ready;
   assign enc_ready = !busy_ff || (rsp_ready && left_ff == 4'd1);
   assign load      = enc_valid && enc_ready && (enc.len != 4'd0);

   always_comb begin
      busy_in   = busy_ff;
      left_in   = left_ff;
      code_in   = code_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      if (load) begin
         busy_in   = 1'b1;
         left_in   = enc.len;
         code_in   = enc.code;
         start_in  = offset_ff;
         offset_in = offset_ff + OFFSET_BITS'(enc.len);
      end else if (take) begin
         left_in = left_ff - 4'd1;
         code_in = {8'h00, code_ff[xenc_pkg::MAX_BYTES-1:1]};
         busy_in = (left_ff != 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         left_ff   <= '0;
         offset_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         left_ff   <= left_in;
         offset_ff <= offset_in;
      end
      code_ff  <= code_in;
      start_ff <= start_in;
   end

   assign start_ext = {16'd0, start_ff};

   assign rsp_valid              = busy_ff;
   assign rsp_data.code_byte     = code_ff[0];
   assign rsp_data.last_byte     = (left_ff == 4'd1);
   assign rsp_data.start_offset  = start_ext[15:0];

endmodule

// ----- tb/x86_64_instruction_encoder_test.sv -----
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_test
// Sends directed and random instruction requests to the encoder. The predicted
// machine code bytes and start offsets are queued when a request is accepted.
// Every byte that leaves is checked against them, under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 30;
   localparam int RANDOM_ITEMS = 136;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_SPARSE
   } stall_type;

   typedef struct {
      xenc_pkg::req_type req;
      bit                drain;
   } pending_type;

   // ALU table, indexed by (operation - OP_ADD_RR) / 2
   localparam logic [4:0][7:0] RR_OPCODE  = {8'h21, 8'h09, 8'h39, 8'h29, 8'h01};
   localparam logic [4:0][7:0] ACC_OPCODE = {8'h25, 8'h0D, 8'h3D, 8'h2D, 8'h05};
   localparam logic [4:0][2:0] OPCODE_EXT = {3'd4, 3'd1, 3'd7, 3'd5, 3'd0};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   xenc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   xenc_pkg::rsp_type rsp_data;

   pending_type       pending[$];
   xenc_pkg::rsp_type expected_bytes[$];
   logic [7:0]        code_q[$];
   logic [15:0]       next_offset = '0;
   logic              req_taken = 1'b0;
   int                cycle_count = 0;
   int                error_count = 0;
   int                gap_left = 0;
   int                burst_left = 0;
   int                stall_left = 0;
   stall_type         stall_mode = READY_ALWAYS;

   x86_64_instruction_encoder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic bit fits_signed(logic [63:0] v, int bits);
      logic signed [63:0] sh;
      sh = $signed(v) >>> (bits - 1);
      return (sh == '0) || (sh == '1);
   endfunction

   function automatic logic [7:0] rex_byte(logic [3:0] reg_f, logic [3:0] rm_f);
      return {4'h4, 1'b1, reg_f[3], 1'b0, rm_f[3]};
   endfunction

   function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] reg_f, logic [2:0] rm_f);
      return {md, reg_f, rm_f};
   endfunction

   function automatic void put_le(logic [63:0] v, int n);
      for (int i = 0; i < n; i++) code_q.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_memory_form(logic [7:0] opcode, logic [3:0] reg_f,
                                           logic [3:0] base, logic [31:0] disp);
      bit short_disp;
      short_disp = fits_signed({{32{disp[31]}}, disp}, 8);
      code_q.push_back(rex_byte(reg_f, base));
      code_q.push_back(opcode);
      code_q.push_back(modrm(short_disp ? 2'b01 : 2'b10, reg_f[2:0], base[2:0]));
      if (base[2:0] == 3'd4) code_q.push_back(8'h24);
      put_le({32'b0, disp}, short_disp ? 1 : 4);
   endfunction

   // predicts the bytes of one accepted request and advances the offset
   function automatic void encode_instruction(xenc_pkg::req_type r);
      xenc_pkg::op_type  op;
      logic [3:0]        d;
      logic [3:0]        s;
      logic [63:0]       imm;
      logic [31:0]       disp;
      logic [2:0]        k;
      logic [3:0]        reg_f;
      logic [3:0]        rm_f;
      xenc_pkg::rsp_type e;
      op = xenc_pkg::op_type'(r.operation);
      d = r.dest_reg;
      s = r.src_reg;
      imm = r.immediate;
      disp = r.displacement;
      code_q.delete();
      case (op)
         xenc_pkg::OP_NOP: code_q.push_back(8'h90);
         xenc_pkg::OP_RET: code_q.push_back(8'hC3);
         xenc_pkg::OP_INC:
            code_q = '{rex_byte(4'd0, d), 8'hFF, modrm(2'b11, 3'd0, d[2:0])};
         xenc_pkg::OP_DEC:
            code_q = '{rex_byte(4'd0, d), 8'hFF, modrm(2'b11, 3'd1, d[2:0])};
         xenc_pkg::OP_NEG:
            code_q = '{rex_byte(4'd0, d), 8'hF7, modrm(2'b11, 3'd3, d[2:0])};
         xenc_pkg::OP_CALL: begin
            if (d[3]) code_q.push_back(8'h41);
            code_q.push_back(8'hFF);
            code_q.push_back(modrm(2'b11, 3'd2, d[2:0]));
         end
         xenc_pkg::OP_PUSH, xenc_pkg::OP_POP: begin
            if (d[3]) code_q.push_back(8'h41);
            code_q.push_back((op == xenc_pkg::OP_PUSH ? 8'h50 : 8'h58) | {5'b0, d[2:0]});
         end
         xenc_pkg::OP_IDIV:
            code_q = '{rex_byte(4'd0, d), 8'hF7, modrm(2'b11, 3'd7, d[2:0])};
         xenc_pkg::OP_JMP: begin
            code_q.push_back(8'hE9);
            put_le({32'b0, disp}, 4);
         end
         xenc_pkg::OP_JNE: begin
            code_q = '{8'h0F, 8'h85};
            put_le({32'b0, disp}, 4);
         end
         xenc_pkg::OP_MOVZX:
            code_q = '{rex_byte(d, 4'd0), 8'h0F, 8'hB6, modrm(2'b11, d[2:0], 3'd0)};
         xenc_pkg::OP_SETL: code_q = '{8'h0F, 8'h9C, 8'hC0};
         xenc_pkg::OP_SETG: code_q = '{8'h0F, 8'h9F, 8'hC0};
         xenc_pkg::OP_SETE: code_q = '{8'h0F, 8'h94, 8'hC0};
         xenc_pkg::OP_IMUL_RR:
            code_q = '{rex_byte(d, s), 8'h0F, 8'hAF, modrm(2'b11, d[2:0], s[2:0])};
         xenc_pkg::OP_IMUL_RI: begin
            code_q = '{rex_byte(d, d), 8'h69, modrm(2'b11, d[2:0], d[2:0])};
            put_le(imm, 4);
         end
         xenc_pkg::OP_MOV_RR:
            code_q = '{rex_byte(s, d), 8'h89, modrm(2'b11, s[2:0], d[2:0])};
         xenc_pkg::OP_MOV_RI: begin
            code_q.push_back(rex_byte(4'd0, d));
            if (fits_signed(imm, 32)) begin
               code_q.push_back(8'hC7);
               code_q.push_back(modrm(2'b11, 3'd0, d[2:0]));
               put_le(imm, 4);
            end else begin
               code_q.push_back(8'hB8 | {5'b0, d[2:0]});
               put_le(imm, 8);
            end
         end
         xenc_pkg::OP_MOV_LOAD: put_memory_form(8'h8B, d, s, disp);
         xenc_pkg::OP_MOV_STORE: put_memory_form(8'h89, s, d, disp);
         xenc_pkg::OP_UNUSED: ;
         default: begin
            k = 3'((r.operation - 5'd15) >> 1);
            if (k > 3'd4) k = 3'd4;
            if (r.operation[0]) begin
               reg_f = (k == xenc_pkg::ALU_CMP) ? d : s;
               rm_f = (k == xenc_pkg::ALU_CMP) ? s : d;
               code_q = '{rex_byte(reg_f, rm_f), RR_OPCODE[k],
                          modrm(2'b11, reg_f[2:0], rm_f[2:0])};
            end else begin
               code_q.push_back(rex_byte(4'd0, d));
               if (fits_signed(imm, 8)) begin
                  code_q.push_back(8'h83);
                  code_q.push_back(modrm(2'b11, OPCODE_EXT[k], d[2:0]));
                  put_le(imm, 1);
               end else if (d == 4'd0) begin
                  code_q.push_back(ACC_OPCODE[k]);
                  put_le(imm, 4);
               end else begin
                  code_q.push_back(8'h81);
                  code_q.push_back(modrm(2'b11, OPCODE_EXT[k], d[2:0]));
                  put_le(imm, 4);
               end
            end
         end
      endcase
      foreach (code_q[i]) begin
         e.code_byte = code_q[i];
         e.last_byte = (i == code_q.size() - 1);
         e.start_offset = next_offset;
         expected_bytes.push_back(e);
      end
      next_offset = next_offset + 16'(code_q.size());
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic queue_item(input xenc_pkg::op_type op, input int d, input int s,
                             input logic [63:0] imm, input logic [31:0] disp,
                             input bit drain);
      pending_type p;
      p.req.operation = op;
      p.req.dest_reg = 4'(d);
      p.req.src_reg = 4'(s);
      p.req.immediate = imm;
      p.req.displacement = disp;
      p.drain = drain;
      pending.push_back(p);
   endtask

   function automatic logic [63:0] pick_value();
      logic signed [7:0]  v8;
      logic signed [31:0] v32;
      logic [63:0]        v;
      case ($urandom_range(0, 3))
         0: begin
            v8 = 8'($urandom());
            v = 64'(v8);
         end
         1: begin
            case ($urandom_range(0, 9))
               0: v = 64'd127;
               1: v = 64'd128;
               2: v = -64'sd128;
               3: v = -64'sd129;
               4: v = 64'h0000_0000_7FFF_FFFF;
               5: v = 64'h0000_0000_8000_0000;
               6: v = 64'hFFFF_FFFF_8000_0000;
               7: v = 64'hFFFF_FFFF_7FFF_FFFF;
               8: v = '0;
               default: v = '1;
            endcase
         end
         2: begin
            v32 = $urandom();
            v = 64'(v32);
         end
         default: v = {$urandom(), $urandom()};
      endcase
      return v;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (gap_left != 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending.size() != 0 &&
                   !(pending[0].drain && expected_bytes.size() != 0)) begin
         req_data <= pending[0].req;
         req_valid <= 1'b1;
         pending.pop_front();
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 80);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         READY_PERIODIC: rsp_ready <= (cycle_count % 5 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // monitor and checker
   always @(posedge clock) begin
      xenc_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) encode_instruction(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h", rsp_data.code_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.code_byte !== want.code_byte)
                  report_mismatch($sformatf("code_byte %h, want %h",
                                            rsp_data.code_byte, want.code_byte));
               if (rsp_data.last_byte !== want.last_byte)
                  report_mismatch($sformatf("last_byte %b, want %b",
                                            rsp_data.last_byte, want.last_byte));
               if (rsp_data.start_offset !== want.start_offset)
                  report_mismatch($sformatf("start_offset %h, want %h",
                                            rsp_data.start_offset, want.start_offset));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      pending_type p;
      // directed: every operation, boundaries of the immediate and displacement tests
      queue_item(xenc_pkg::OP_NOP, 0, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_RET, 15, 15, '1, '1, 0);
      queue_item(xenc_pkg::OP_INC, 15, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_DEC, 7, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_NEG, 8, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_CALL, 9, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_PUSH, 12, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_POP, 3, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_IDIV, 11, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_JMP, 0, 0, '0, 32'h7FFF_FFFF, 0);
      queue_item(xenc_pkg::OP_JNE, 0, 0, '0, 32'h8000_0000, 0);
      queue_item(xenc_pkg::OP_MOVZX, 14, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_SETL, 0, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_SETG, 0, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_SETE, 0, 0, '0, '0, 0);
      queue_item(xenc_pkg::OP_ADD_RR, 8, 15, '0, '0, 0);
      queue_item(xenc_pkg::OP_ADD_RI, 15, 0, 64'd127, '0, 0);
      queue_item(xenc_pkg::OP_SUB_RR, 2, 10, '0, '0, 0);
      queue_item(xenc_pkg::OP_SUB_RI, 6, 0, -64'sd128, '0, 0);
      queue_item(xenc_pkg::OP_CMP_RR, 13, 1, '0, '0, 0);
      queue_item(xenc_pkg::OP_CMP_RI, 0, 0, 64'd128, '0, 0);
      queue_item(xenc_pkg::OP_OR_RR, 4, 5, '0, '0, 0);
      queue_item(xenc_pkg::OP_OR_RI, 9, 0, -64'sd129, '0, 0);
      queue_item(xenc_pkg::OP_AND_RR, 0, 8, '0, '0, 0);
      queue_item(xenc_pkg::OP_AND_RI, 0, 0, 64'h1_0000_0000, '0, 0);
      queue_item(xenc_pkg::OP_IMUL_RR, 10, 3, '0, '0, 0);
      queue_item(xenc_pkg::OP_IMUL_RI, 12, 0, 64'h8000_0000_0000_0001, '0, 0);
      queue_item(xenc_pkg::OP_MOV_RR, 1, 12, '0, '0, 0);
      queue_item(xenc_pkg::OP_MOV_RI, 5, 0, 64'hFFFF_FFFF_8000_0000, '0, 0);
      queue_item(xenc_pkg::OP_MOV_RI, 13, 0, 64'h0000_0000_8000_0000, '0, 1);
      queue_item(xenc_pkg::OP_MOV_LOAD, 15, 4, '0, 32'd127, 0);
      queue_item(xenc_pkg::OP_MOV_STORE, 12, 9, '0, -32'sd129, 0);
      queue_item(xenc_pkg::OP_MOV_LOAD, 2, 13, '0, '0, 0);
      queue_item(xenc_pkg::OP_UNUSED, 15, 15, '1, '1, 0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         p.req.operation = 5'($urandom_range(0, 31));
         p.req.dest_reg = 4'($urandom_range(0, 15));
         p.req.src_reg = 4'($urandom_range(0, 15));
         p.req.immediate = pick_value();
         p.req.displacement = 32'(pick_value());
         p.drain = ($urandom_range(0, 29) == 0);
         pending.push_back(p);
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
